// ===== hw/rtl/horizontal_run_length_histogram_core_macros.svh =====
// Assertion macros shared by the run-length histogram RTL.
// Each macro expects signals named clk and rst_n in the calling module.
`ifndef HORIZONTAL_RUN_LENGTH_HISTOGRAM_CORE_MACROS_SVH
`define HORIZONTAL_RUN_LENGTH_HISTOGRAM_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define HRLH_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define HRLH_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/hrlh_pkg.sv =====
package hrlh_pkg;

    localparam int HIST_BINS  = 256;
    localparam int COUNT_BITS = 32;
    localparam int BIN_W      = $clog2(HIST_BINS);

    // Run length counter: counts up to and holds at 256
    localparam int             LEN_W   = 9;
    localparam logic [LEN_W-1:0] RUN_CAP = 9'd256;

    localparam logic [7:0] START_A = 8'd2;
    localparam logic [7:0] START_B = 8'd6;

    localparam logic [7:0] MIN_LENGTH_RESET = 8'd4;
    localparam logic [7:0] MAX_LENGTH_RESET = 8'd80;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH = 1'd1;

    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    // Queue between front and back; depth must be a power of two
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    // Bin 1 lives in a flip-flop of its own in the back end
    localparam logic [BIN_W-1:0]      BIN_ONE   = BIN_W'(1);

    typedef struct packed {
        logic [7:0] min_length;
        logic [7:0] max_length;
    } cfg_t;

    // One histogram operation, as classified by the front end
    typedef struct packed {
        logic             is_read;  // read and clear, else increment
        logic             oob;      // read index beyond the bins
        logic             main_en;  // increment bin (not bin 1)
        logic [1:0]       one_cnt;  // increments for bin 1
        logic [BIN_W-1:0] bin;
    } op_t;

    function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
                                                      input logic [1:0] inc);
        logic [COUNT_BITS:0] sum;
        sum = {1'b0, a} + (COUNT_BITS + 1)'(inc);
        return (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[COUNT_BITS-1:0];
    endfunction

endpackage

// ===== hw/rtl/hrlh_in_if.sv =====
interface hrlh_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] pixel;
    logic       last_in_row;
    logic [7:0] bin_index;

    modport source (output valid, output func, output pixel, output last_in_row,
                    output bin_index, input ready);
    modport sink   (input valid, input func, input pixel, input last_in_row,
                    input bin_index, output ready);
endinterface

// ===== hw/rtl/hrlh_out_if.sv =====
interface hrlh_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] bin_count;

    modport source (output valid, output bin_count, input ready);
    modport sink   (input valid, input bin_count, output ready);
endinterface

// ===== hw/rtl/hrlh_front.sv =====
`include "horizontal_run_length_histogram_core_macros.svh"

module hrlh_front (
    input  logic                clk,
    input  logic                rst_n,
    input  hrlh_pkg::cfg_t      cfg,
    hrlh_in_if.sink             in_ch,
    input  logic                q_full,
    output logic                push,
    output hrlh_pkg::op_t       push_op
);

    logic                         run_active_reg, run_active_next;
    logic                         run_six_reg, run_six_next;
    logic [hrlh_pkg::LEN_W-1:0]   run_len_reg, run_len_next;

    logic                         accept;
    logic [7:0]                   run_val;
    logic                         match, close_a, close_b;
    logic                         act1, act2, six2, start;
    logic [hrlh_pkg::LEN_W-1:0]   len1, len2;
    logic                         ca, cb, ca_one, cb_one;

    function automatic logic counted(input logic [hrlh_pkg::LEN_W-1:0] l,
                                     input hrlh_pkg::cfg_t c);
        return (l >= hrlh_pkg::LEN_W'(c.min_length)) &&
               (l <= hrlh_pkg::LEN_W'(c.max_length)) &&
               (int'(l) < hrlh_pkg::HIST_BINS);
    endfunction

    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && in_ch.ready;

    always_comb
    begin
        run_val = run_six_reg ? hrlh_pkg::START_B : hrlh_pkg::START_A;
        match   = run_active_reg && (in_ch.pixel == run_val);
        close_a = run_active_reg && !match;
        act1    = match;
        len1    = (match && run_len_reg < hrlh_pkg::RUN_CAP)
                  ? hrlh_pkg::LEN_W'(run_len_reg + hrlh_pkg::LEN_W'(1)) : run_len_reg;
        start   = !act1 && (in_ch.pixel == hrlh_pkg::START_A ||
                            in_ch.pixel == hrlh_pkg::START_B);
        act2    = act1 || start;
        six2    = start ? (in_ch.pixel == hrlh_pkg::START_B) : (act1 && run_six_reg);
        len2    = start ? hrlh_pkg::LEN_W'(1) : len1;
        close_b = in_ch.last_in_row && act2;

        // Both closes only when a new run starts, so len2 is 1 then
        ca      = close_a && counted(run_len_reg, cfg);
        cb      = close_b && counted(len2, cfg);
        ca_one  = ca && (run_len_reg == hrlh_pkg::LEN_W'(1));
        cb_one  = cb && (len2 == hrlh_pkg::LEN_W'(1));

        run_active_next = close_b ? 1'b0 : act2;
        run_six_next    = close_b ? 1'b0 : six2;
        run_len_next    = close_b ? '0 : (act2 ? len2 : '0);

        push_op = '0;
        if (in_ch.func == hrlh_pkg::FUNC_READ)
        begin
            push_op.is_read = 1'b1;
            push_op.oob     = !(int'(in_ch.bin_index) < hrlh_pkg::HIST_BINS);
            push_op.bin     = hrlh_pkg::BIN_W'(in_ch.bin_index);
        end
        else
        begin
            push_op.main_en = (ca && !ca_one) || (cb && !cb_one);
            push_op.one_cnt = {1'b0, ca_one} + {1'b0, cb_one};
            push_op.bin     = (ca && !ca_one) ? hrlh_pkg::BIN_W'(run_len_reg)
                                              : hrlh_pkg::BIN_W'(len2);
        end
        push = accept && (push_op.is_read || push_op.main_en || push_op.one_cnt != 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_active_reg <= 1'b0;
            run_six_reg    <= 1'b0;
            run_len_reg    <= '0;
        end
        else if (accept && in_ch.func == hrlh_pkg::FUNC_PIXEL)
        begin
            run_active_reg <= run_active_next;
            run_six_reg    <= run_six_next;
            run_len_reg    <= run_len_next;
        end
    end

    `HRLH_ASSERT_IMPL(a_len_tracks_active, 1'b1,
                      run_active_reg == (run_len_reg != '0),
                      "run length and run activity disagree")
    `HRLH_ASSERT_NEXT(a_row_end_closes, accept && in_ch.func == hrlh_pkg::FUNC_PIXEL &&
                      in_ch.last_in_row, !run_active_reg,
                      "run still open after the end of a row")

endmodule

// ===== hw/rtl/hrlh_queue.sv =====
`include "horizontal_run_length_histogram_core_macros.svh"

module hrlh_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  hrlh_pkg::op_t   push_op,
    input  logic            pop,
    output hrlh_pkg::op_t   head,
    output logic            empty,
    output logic            full
);

    hrlh_pkg::op_t                 slot_reg [hrlh_pkg::QUEUE_DEPTH];
    logic [hrlh_pkg::QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [hrlh_pkg::QCNT_W-1:0]   count_reg;

    assign head  = slot_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign full  = (count_reg == hrlh_pkg::QCNT_W'(hrlh_pkg::QUEUE_DEPTH));

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + hrlh_pkg::QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + hrlh_pkg::QPTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + hrlh_pkg::QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - hrlh_pkg::QCNT_W'(1);
            end
        end
    end

    `HRLH_ASSERT_IMPL(a_no_underflow, pop, count_reg != '0, "pop from an empty queue")

endmodule

// ===== hw/rtl/hrlh_back.sv =====
`include "horizontal_run_length_histogram_core_macros.svh"

module hrlh_back (
    input  logic            clk,
    input  logic            rst_n,
    input  hrlh_pkg::op_t   head,
    input  logic            q_empty,
    output logic            pop,
    hrlh_out_if.source      out_ch
);

    logic [hrlh_pkg::COUNT_BITS-1:0] count_mem [hrlh_pkg::HIST_BINS];
    logic [hrlh_pkg::HIST_BINS-1:0]  bin_valid_reg;

    logic                            s1_valid_reg;
    hrlh_pkg::op_t                   s1_op_reg;
    logic [hrlh_pkg::COUNT_BITS-1:0] rd_data_reg;
    logic                            rd_valid_reg;
    logic                            byp_hit_reg;
    logic [hrlh_pkg::COUNT_BITS-1:0] byp_data_reg;
    logic [hrlh_pkg::COUNT_BITS-1:0] one_count_reg, one_count_next;
    logic                            out_valid_reg;
    logic [hrlh_pkg::COUNT_BITS-1:0] out_count_reg;

    logic                            s1_go, retire, is_one;
    logic [hrlh_pkg::COUNT_BITS-1:0] old_main, rd_result, wr_data;
    logic                            mem_we;

    assign s1_go  = !s1_valid_reg || !(s1_op_reg.is_read && out_valid_reg && !out_ch.ready);
    assign pop    = s1_go && !q_empty;
    assign retire = s1_valid_reg && s1_go;
    assign is_one = (s1_op_reg.bin == hrlh_pkg::BIN_ONE);

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.bin_count = out_count_reg;

    always_comb
    begin
        old_main       = byp_hit_reg ? byp_data_reg : (rd_valid_reg ? rd_data_reg : '0);
        rd_result      = '0;
        wr_data        = '0;
        mem_we         = 1'b0;
        one_count_next = one_count_reg;
        if (s1_op_reg.is_read)
        begin
            if (!s1_op_reg.oob)
            begin
                if (is_one)
                begin
                    rd_result      = one_count_reg;
                    one_count_next = '0;
                end
                else
                begin
                    rd_result = old_main;
                    mem_we    = retire;
                end
            end
        end
        else
        begin
            wr_data        = hrlh_pkg::sat_add(old_main, 2'd1);
            mem_we         = retire && s1_op_reg.main_en;
            one_count_next = hrlh_pkg::sat_add(one_count_reg, s1_op_reg.one_cnt);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            count_mem[s1_op_reg.bin] <= wr_data;
        end
        if (pop)
        begin
            rd_data_reg  <= count_mem[head.bin];
            byp_data_reg <= wr_data;
            s1_op_reg    <= head;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_valid_reg <= '0;
            s1_valid_reg  <= 1'b0;
            rd_valid_reg  <= 1'b0;
            byp_hit_reg   <= 1'b0;
            one_count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (mem_we)
            begin
                bin_valid_reg[s1_op_reg.bin] <= 1'b1;
            end
            if (s1_go)
            begin
                s1_valid_reg <= pop;
            end
            if (pop)
            begin
                rd_valid_reg <= bin_valid_reg[head.bin];
                byp_hit_reg  <= mem_we && (s1_op_reg.bin == head.bin);
            end
            if (retire)
            begin
                one_count_reg <= one_count_next;
            end
            if (retire && s1_op_reg.is_read)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (retire && s1_op_reg.is_read)
        begin
            out_count_reg <= rd_result;
        end
    end

    `HRLH_ASSERT_NEXT(a_stall_holds_op, s1_valid_reg && !s1_go,
                      s1_valid_reg && $stable(s1_op_reg),
                      "stalled operation changed")
    `HRLH_ASSERT_IMPL(a_bin_one_not_in_mem, mem_we, s1_op_reg.bin != hrlh_pkg::BIN_ONE,
                      "bin 1 written to the count memory")
    `HRLH_ASSERT_NEXT(a_read_gives_result, retire && s1_op_reg.is_read, out_valid_reg,
                      "retired read produced no result")

endmodule

// ===== hw/rtl/horizontal_run_length_histogram_core.sv =====
// A read passes the queue, the stage-1 operation register and the result register before its
// bin_count is on the output; pixel transactions return nothing. Throughput: one transaction
// per cycle while the queue has room and out_ch.ready does not hold back a read result, set
// by the single read-modify-write port of the bin memory, which forwards back-to-back updates
// of the same bin. Reset: clears the run state, the queue, the output valid flag
// and every bin at once, bin 1 in its register, the rest by per-bin flags; no clearing pass.
module horizontal_run_length_histogram_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [hrlh_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [7:0]                        cfg_data,
    hrlh_in_if.sink                           in_ch,
    hrlh_out_if.source                        out_ch
);

    // Run thresholds: user writes them only while the block is idle; not enforced by the block
    hrlh_pkg::cfg_t cfg_reg;

    // Front to queue, queue to back
    logic          push, pop, q_empty, q_full;
    hrlh_pkg::op_t push_op, head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_length <= hrlh_pkg::MIN_LENGTH_RESET;
            cfg_reg.max_length <= hrlh_pkg::MAX_LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                hrlh_pkg::REG_MIN_LENGTH: cfg_reg.min_length <= cfg_data;
                hrlh_pkg::REG_MAX_LENGTH: cfg_reg.max_length <= cfg_data;
                default:                  cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Front: track runs, turn each closed counted run or read into a histogram operation
    hrlh_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .in_ch   (in_ch),
        .q_full  (q_full),
        .push    (push),
        .push_op (push_op)
    );

    // Queue: decouple run tracking from the bin memory so each side stalls on its own
    hrlh_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head    (head),
        .empty   (q_empty),
        .full    (q_full)
    );

    // Back: read-modify-write the bins, hold read results for the output channel
    hrlh_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .q_empty (q_empty),
        .pop     (pop),
        .out_ch  (out_ch)
    );

endmodule
